// ===== hdl/btx_pkg.sv =====
// Package for the bilinear texel sampler.
// Holds the sizes, codes, shared types and the fixed-point helper functions.
// No dependencies.
package btx_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int FRAC_BITS   = 8;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = 6;
  localparam int SIZE_W      = 7;
  localparam int FRAC_W      = 8;
  localparam int CHAN_W      = 8;
  localparam int TEXEL_W     = 3 * CHAN_W;
  localparam int ACC_W       = CHAN_W + FRAC_BITS + 1;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [TEXEL_W-1:0] texel_t;

  typedef struct packed {
    texel_t                t00;
    texel_t                t10;
    texel_t                t01;
    texel_t                t11;
    logic [FRAC_BITS-1:0]  frac_h;
    logic [FRAC_BITS-1:0]  frac_v;
  } quad_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] res;
    if (r == '0) begin
      res = SIZE_W'(1);
    end else if (r > maxv) begin
      res = maxv;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input logic [SIZE_W-1:0] p,
                                                 input logic [POS_W-1:0] lim);
    logic [POS_W-1:0] res;
    if (p > {1'b0, lim}) begin
      res = lim;
    end else begin
      res = p[POS_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] texel_addr(input logic [SIZE_W-1:0] w,
                                                   input logic [POS_W-1:0] v,
                                                   input logic [POS_W-1:0] h);
    logic [SIZE_W+POS_W-1:0] prod;
    logic [SIZE_W+POS_W-1:0] sum;
    prod = (SIZE_W + POS_W)'(w) * (SIZE_W + POS_W)'(v);
    sum  = prod + (SIZE_W + POS_W)'(h);
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0] fw;
    logic [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]   sh;
    logic [CHAN_W-1:0]  res;
    fw  = (FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, f};
    acc = ACC_W'(a) * ACC_W'(fw) + ACC_W'(b) * ACC_W'(f);
    sh  = acc >> FRAC_BITS;
    if (sh > ACC_W'(CHAN_MAX)) begin
      res = CHAN_MAX;
    end else begin
      res = sh[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/btx_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// Read returns the old contents on a same-cycle write. No dependencies.
module btx_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/btx_filter.sv =====
// Two-stage bilinear filter: vertical blends, then the horizontal blend.
// Depends on btx_pkg for the texel quad type and the blend function.
module btx_filter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  quad_valid,
  input  btx_pkg::quad_t        quad,
  output logic                  res_valid,
  output logic [btx_pkg::CHAN_W-1:0] res_red,
  output logic [btx_pkg::CHAN_W-1:0] res_green,
  output logic [btx_pkg::CHAN_W-1:0] res_blue
);
  import btx_pkg::*;

  logic                 vld1_r;
  logic                 vld2_r;
  texel_t               left_r, left_nxt;
  texel_t               right_r, right_nxt;
  logic [FRAC_BITS-1:0] frac_h_r;
  texel_t               res_r, res_nxt;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      left_nxt[ch*CHAN_W +: CHAN_W]  = blend(quad.t00[ch*CHAN_W +: CHAN_W],
                                             quad.t01[ch*CHAN_W +: CHAN_W], quad.frac_v);
      right_nxt[ch*CHAN_W +: CHAN_W] = blend(quad.t10[ch*CHAN_W +: CHAN_W],
                                             quad.t11[ch*CHAN_W +: CHAN_W], quad.frac_v);
      res_nxt[ch*CHAN_W +: CHAN_W]   = blend(left_r[ch*CHAN_W +: CHAN_W],
                                             right_r[ch*CHAN_W +: CHAN_W], frac_h_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= quad_valid;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    frac_h_r <= quad.frac_h;
    res_r    <= res_nxt;
  end

  assign res_valid = vld2_r;
  assign res_red   = res_r[2*CHAN_W +: CHAN_W];
  assign res_green = res_r[CHAN_W +: CHAN_W];
  assign res_blue  = res_r[0 +: CHAN_W];

endmodule

// ===== hdl/bilinear_texel_sampler.sv =====
// Top level of the bilinear texel sampler: APB register file, fetch sequencer
// and texel memory. Depends on btx_pkg, btx_ram and btx_filter.
//
//   Channel   Handshake                    Payload
//   input     start, busy                  in_cmd, in_pos_h/v, in_frac_h/v, in_red/green/blue
//   result    out_valid (one-cycle strobe) out_red, out_green, out_blue
//   config    psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// A texel write does not raise busy, so another transaction can be accepted in the next cycle.
// A sample's four neighbor reads share the single port of the texel memory, one read
// per cycle, and busy stays high after start until the last of the four reads is issued.
// The result strobe follows the last texel read through the memory's registered read port and the two filter stages.
// Reset clears the control state and sets both size registers to 64; texel memory contents are kept.
module bilinear_texel_sampler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [btx_pkg::POS_W-1:0]     in_pos_h,
  input  logic [btx_pkg::POS_W-1:0]     in_pos_v,
  input  logic [btx_pkg::FRAC_W-1:0]    in_frac_h,
  input  logic [btx_pkg::FRAC_W-1:0]    in_frac_v,
  input  logic [btx_pkg::CHAN_W-1:0]    in_red,
  input  logic [btx_pkg::CHAN_W-1:0]    in_green,
  input  logic [btx_pkg::CHAN_W-1:0]    in_blue,
  output logic                          out_valid,
  output logic [btx_pkg::CHAN_W-1:0]    out_red,
  output logic [btx_pkg::CHAN_W-1:0]    out_green,
  output logic [btx_pkg::CHAN_W-1:0]    out_blue,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btx_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [btx_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [btx_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import btx_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]    width_r;
  logic [SIZE_W-1:0]    height_r;
  logic [SIZE_W-1:0]    w_eff;
  logic [SIZE_W-1:0]    h_eff;
  logic [SIZE_W-1:0]    wm1;
  logic [SIZE_W-1:0]    hm1;
  logic [POS_W-1:0]     h0, h1, v0, v1;
  logic [POS_W-1:0]     h0_r, h1_r, v0_r, v1_r;
  logic [FRAC_BITS-1:0] frac_h_r, frac_v_r;
  logic                 accept;
  logic                 sample_acc;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  texel_t               ram_wdata;
  texel_t               ram_rdata;
  logic                 rd_vld_r;
  logic [1:0]           rd_idx_r;
  texel_t               t00_r, t10_r, t01_r;
  logic                 quad_valid;
  quad_t                quad;

  assign busy       = (state_r == S_FETCH);
  assign accept     = start && !busy;
  assign sample_acc = accept && (in_cmd == CMD_SAMPLE);
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT: prdata = CFG_DATA_W'(height_r);
    endcase
  end

  assign w_eff = eff_size(width_r, SIZE_W'(MAX_WIDTH));
  assign h_eff = eff_size(height_r, SIZE_W'(MAX_HEIGHT));
  assign wm1   = w_eff - SIZE_W'(1);
  assign hm1   = h_eff - SIZE_W'(1);
  assign h0    = clamp_pos(SIZE_W'(in_pos_h), wm1[POS_W-1:0]);
  assign h1    = clamp_pos(SIZE_W'(in_pos_h) + SIZE_W'(1), wm1[POS_W-1:0]);
  assign v0    = clamp_pos(SIZE_W'(in_pos_v), hm1[POS_W-1:0]);
  assign v1    = clamp_pos(SIZE_W'(in_pos_v) + SIZE_W'(1), hm1[POS_W-1:0]);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (sample_acc) begin
          state_nxt = S_FETCH;
          cnt_nxt   = 2'd1;
        end
      end
      S_FETCH: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= sample_acc || busy;
      rd_idx_r <= busy ? cnt_r : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_acc) begin
      h0_r     <= h0;
      h1_r     <= h1;
      v0_r     <= v0;
      v1_r     <= v1;
      frac_h_r <= in_frac_h[FRAC_BITS-1:0];
      frac_v_r <= in_frac_v[FRAC_BITS-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {in_red, in_green, in_blue};
    if (busy) begin
      ram_addr = texel_addr(w_eff, cnt_r[1] ? v1_r : v0_r, cnt_r[0] ? h1_r : h0_r);
    end else begin
      ram_addr = texel_addr(w_eff, v0, h0);
      ram_we   = accept && (in_cmd == CMD_WRITE) &&
                 (SIZE_W'(in_pos_h) < w_eff) && (SIZE_W'(in_pos_v) < h_eff);
    end
  end

  btx_ram #(
    .DATA_W(TEXEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      unique case (rd_idx_r)
        2'd0:    t00_r <= ram_rdata;
        2'd1:    t10_r <= ram_rdata;
        2'd2:    t01_r <= ram_rdata;
        default: begin
        end
      endcase
    end
  end

  assign quad_valid  = rd_vld_r && (rd_idx_r == 2'd3);
  assign quad.t00    = t00_r;
  assign quad.t10    = t10_r;
  assign quad.t01    = t01_r;
  assign quad.t11    = ram_rdata;
  assign quad.frac_h = frac_h_r;
  assign quad.frac_v = frac_v_r;

  btx_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .quad_valid(quad_valid),
    .quad      (quad),
    .res_valid (out_valid),
    .res_red   (out_red),
    .res_green (out_green),
    .res_blue  (out_blue)
  );

  a_last_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH && cnt_r == 2'd3) |-> ##3 out_valid)
    else $error("sample result strobe missing after last texel read");

  a_no_write_while_fetching: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("texel write during a sample fetch");

  a_sample_starts_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> (state_r == S_FETCH && cnt_r == 2'd1))
    else $error("accepted sample did not start the fetch sequence");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_WRITE) |=> (state_r == S_IDLE && !rd_vld_r))
    else $error("texel write started a read sequence");

  a_quad_once_per_sample: assert property (@(posedge clk) disable iff (!rst_n)
    quad_valid |-> ($past(state_r) == S_FETCH && $past(cnt_r) == 2'd3))
    else $error("filter fed without a completed fetch");

endmodule

// ===== dv/texel_filter_checker.sv =====
// Checker for the bilinear texel sampler: follows register writes and texel writes, checks
// register reads, predicts every filtered sample and compares it with the result strobe.
// Depends on btx_pkg.
module texel_filter_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_cmd,
  input  logic [btx_pkg::POS_W-1:0]      in_pos_h,
  input  logic [btx_pkg::POS_W-1:0]      in_pos_v,
  input  logic [btx_pkg::FRAC_W-1:0]     in_frac_h,
  input  logic [btx_pkg::FRAC_W-1:0]     in_frac_v,
  input  logic [btx_pkg::CHAN_W-1:0]     in_red,
  input  logic [btx_pkg::CHAN_W-1:0]     in_green,
  input  logic [btx_pkg::CHAN_W-1:0]     in_blue,
  input  logic                           out_valid,
  input  logic [btx_pkg::CHAN_W-1:0]     out_red,
  input  logic [btx_pkg::CHAN_W-1:0]     out_green,
  input  logic [btx_pkg::CHAN_W-1:0]     out_blue,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btx_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [btx_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [btx_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending,
  output int                             compared
);
  import btx_pkg::*;

  localparam int SUM_W = CHAN_W + FRAC_BITS + 1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  texel_t            texture [STORE_DEPTH];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  rgb_t              filtered_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    compared   = 0;
  end

  function automatic int usable_size(input logic [SIZE_W-1:0] r, input int limit);
    int res;
    if (r == '0) begin
      res = 1;
    end else if (int'(r) > limit) begin
      res = limit;
    end else begin
      res = int'(r);
    end
    return res;
  endfunction

  function automatic texel_t texel_at(input int h, input int v, input int w, input int ht);
    int ch;
    int cv;
    ch = (h >= w) ? w - 1 : h;
    cv = (v >= ht) ? ht - 1 : v;
    return texture[w * cv + ch];
  endfunction

  function automatic logic [CHAN_W-1:0] lerp(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b,
                                             input logic [FRAC_BITS-1:0] f);
    logic [SUM_W-1:0] wa;
    logic [SUM_W-1:0] wb;
    logic [SUM_W-1:0] sum;
    wb  = SUM_W'(f);
    wa  = SUM_W'(1 << FRAC_BITS) - wb;
    sum = (SUM_W'(a) * wa + SUM_W'(b) * wb) >> FRAC_BITS;
    return (sum > SUM_W'(CHAN_MAX)) ? CHAN_MAX : sum[CHAN_W-1:0];
  endfunction

  // Vertical pass first on both columns, then the horizontal pass between them.
  function automatic rgb_t filter_quad(input int h, input int v,
                                       input logic [FRAC_BITS-1:0] fh,
                                       input logic [FRAC_BITS-1:0] fv);
    int     w;
    int     ht;
    texel_t q00;
    texel_t q10;
    texel_t q01;
    texel_t q11;
    logic [CHAN_W-1:0] left;
    logic [CHAN_W-1:0] right;
    rgb_t   res;
    w   = usable_size(width_reg, MAX_WIDTH);
    ht  = usable_size(height_reg, MAX_HEIGHT);
    q00 = texel_at(h, v, w, ht);
    q10 = texel_at(h + 1, v, w, ht);
    q01 = texel_at(h, v + 1, w, ht);
    q11 = texel_at(h + 1, v + 1, w, ht);
    for (int c = 0; c < 3; c++) begin
      left  = lerp(q00[CHAN_W*(2-c) +: CHAN_W], q01[CHAN_W*(2-c) +: CHAN_W], fv);
      right = lerp(q10[CHAN_W*(2-c) +: CHAN_W], q11[CHAN_W*(2-c) +: CHAN_W], fv);
      res[CHAN_W*(2-c) +: CHAN_W] = lerp(left, right, fh);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    int   w;
    int   ht;
    rgb_t want;
    if (!rst_n) begin
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      filtered_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (int'(paddr) >> 2)
            int'(REG_WIDTH):  width_reg  = pwdata[SIZE_W-1:0];
            int'(REG_HEIGHT): height_reg = pwdata[SIZE_W-1:0];
            default: ;
          endcase
        end else begin
          case (int'(paddr) >> 2)
            int'(REG_WIDTH): begin
              if (prdata !== CFG_DATA_W'(width_reg))
                report_mismatch($sformatf("width read %0h, expected %0h", prdata, width_reg));
            end
            int'(REG_HEIGHT): begin
              if (prdata !== CFG_DATA_W'(height_reg))
                report_mismatch($sformatf("height read %0h, expected %0h", prdata, height_reg));
            end
            default: ;
          endcase
        end
      end
      if (start && !busy) begin
        if (cmd_t'(in_cmd) == CMD_SAMPLE) begin
          filtered_q.push_back(filter_quad(int'(in_pos_h), int'(in_pos_v),
                                           in_frac_h[FRAC_BITS-1:0],
                                           in_frac_v[FRAC_BITS-1:0]));
        end else begin
          w  = usable_size(width_reg, MAX_WIDTH);
          ht = usable_size(height_reg, MAX_HEIGHT);
          if (int'(in_pos_h) < w && int'(in_pos_v) < ht)
            texture[w * int'(in_pos_v) + int'(in_pos_h)] = {in_red, in_green, in_blue};
        end
      end
      if (out_valid) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h %h %h", out_red, out_green, out_blue));
        end else begin
          want = filtered_q.pop_front();
          compared++;
          if (out_red !== want.red)
            report_mismatch($sformatf("red %h, expected %h", out_red, want.red));
          if (out_green !== want.green)
            report_mismatch($sformatf("green %h, expected %h", out_green, want.green));
          if (out_blue !== want.blue)
            report_mismatch($sformatf("blue %h, expected %h", out_blue, want.blue));
        end
      end
    end
    pending = filtered_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the bilinear texel sampler testbench: clock, reset, APB size settings and
// texel write and sample transactions. Depends on btx_pkg, bilinear_texel_sampler
// and texel_filter_checker.
module testbench;
  import btx_pkg::*;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int SETTLE_CYCLES   = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_cmd;
  logic [POS_W-1:0]      in_pos_h;
  logic [POS_W-1:0]      in_pos_v;
  logic [FRAC_W-1:0]     in_frac_h;
  logic [FRAC_W-1:0]     in_frac_v;
  logic [CHAN_W-1:0]     in_red;
  logic [CHAN_W-1:0]     in_green;
  logic [CHAN_W-1:0]     in_blue;
  logic                  out_valid;
  logic [CHAN_W-1:0]     out_red;
  logic [CHAN_W-1:0]     out_green;
  logic [CHAN_W-1:0]     out_blue;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int compared;
  int cycles;
  int sent;
  int settings_used;
  int cur_w;
  int cur_h;
  bit calm;
  bit written [STORE_DEPTH];

  bilinear_texel_sampler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_pos_h(in_pos_h), .in_pos_v(in_pos_v),
    .in_frac_h(in_frac_h), .in_frac_v(in_frac_v),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  texel_filter_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_pos_h(in_pos_h), .in_pos_v(in_pos_v),
    .in_frac_h(in_frac_h), .in_frac_v(in_frac_v),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending), .compared(compared)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int clip_size(input int r, input int limit);
    return (r == 0) ? 1 : (r > limit) ? limit : r;
  endfunction

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start     <= 1'b0;
      in_cmd    <= 1'($urandom_range(0, 1));
      in_pos_h  <= POS_W'($urandom);
      in_pos_v  <= POS_W'($urandom);
      in_frac_h <= FRAC_W'($urandom);
      in_frac_v <= FRAC_W'($urandom);
      in_red    <= CHAN_W'($urandom);
      in_green  <= CHAN_W'($urandom);
      in_blue   <= CHAN_W'($urandom);
    end
  endtask

  task automatic issue(input cmd_t c, input int h, input int v,
                       input logic [FRAC_W-1:0] fh, input logic [FRAC_W-1:0] fv,
                       input texel_t color);
    if (!calm && $urandom_range(0, 3) == 0) idle($urandom_range(1, 6));
    @(negedge clk);
    start     <= 1'b1;
    in_cmd    <= c;
    in_pos_h  <= POS_W'(h);
    in_pos_v  <= POS_W'(v);
    in_frac_h <= fh;
    in_frac_v <= fv;
    in_red    <= color[2*CHAN_W +: CHAN_W];
    in_green  <= color[CHAN_W +: CHAN_W];
    in_blue   <= color[0 +: CHAN_W];
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic write_texel(input int h, input int v, input texel_t color);
    issue(CMD_WRITE, h, v, FRAC_W'($urandom), FRAC_W'($urandom), color);
    if (h < cur_w && v < cur_h) written[cur_w * v + h] = 1'b1;
  endtask

  // Every neighbor that the sample will read is written first, so no unwritten
  // texel is ever read.
  task automatic sample(input int h, input int v,
                        input logic [FRAC_W-1:0] fh, input logic [FRAC_W-1:0] fv);
    int ch;
    int cv;
    for (int d = 0; d < 4; d++) begin
      ch = (h + d % 2 >= cur_w) ? cur_w - 1 : h + d % 2;
      cv = (v + d / 2 >= cur_h) ? cur_h - 1 : v + d / 2;
      if (!written[cur_w * cv + ch]) write_texel(ch, cv, texel_t'($urandom));
    end
    issue(CMD_SAMPLE, h, v, fh, fv, texel_t'($urandom));
  endtask

  task automatic reg_access(input logic wr, input reg_idx_t idx, input logic [SIZE_W-1:0] val);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[SIZE_W-1:0] = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_ADDR_W'(4 * int'(idx));
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    idle(1);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    drain();
    reg_access(1'b1, REG_WIDTH, SIZE_W'(w));
    reg_access(1'b1, REG_HEIGHT, SIZE_W'(h));
    reg_access(1'b0, REG_WIDTH, '0);
    reg_access(1'b0, REG_HEIGHT, '0);
    cur_w = clip_size(w, MAX_WIDTH);
    cur_h = clip_size(h, MAX_HEIGHT);
    settings_used++;
  endtask

  function automatic logic [FRAC_W-1:0] pick_frac();
    int r;
    r = $urandom_range(0, 9);
    return (r == 0) ? '0 : (r == 1) ? '1 : FRAC_W'($urandom);
  endfunction

  initial begin
    int phase_w [PHASES];
    int phase_h [PHASES];
    int r;
    phase_w = '{1, 0, 127, 64, 1, 2, 17, 65, 0, 64};
    phase_h = '{1, 0, 127, 1, 64, 2, 9, 33, 0, 64};
    phase_w[8] = $urandom_range(0, 127);
    phase_h[8] = $urandom_range(0, 127);
    sent = 0;
    settings_used = 1;
    calm = 1'b0;
    cur_w = MAX_WIDTH;
    cur_h = MAX_HEIGHT;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_cmd  = CMD_WRITE;
    {in_pos_h, in_pos_v, in_frac_h, in_frac_v} = '0;
    {in_red, in_green, in_blue} = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset values of both size registers, then corners and fraction extremes.
    reg_access(1'b0, REG_WIDTH, '0);
    reg_access(1'b0, REG_HEIGHT, '0);
    write_texel(0, 0, 24'h000000);
    write_texel(1, 0, 24'hffffff);
    write_texel(0, 1, 24'hffffff);
    write_texel(1, 1, 24'h000000);
    sample(0, 0, 8'h00, 8'h00);
    sample(0, 0, 8'hff, 8'hff);
    sample(0, 0, 8'h00, 8'hff);
    sample(0, 0, 8'hff, 8'h00);
    sample(0, 0, 8'h80, 8'h80);
    write_texel(63, 63, 24'hffffff);
    write_texel(62, 63, 24'h5aa53c);
    write_texel(63, 62, 24'ha55ac3);
    write_texel(62, 62, 24'h000000);
    sample(63, 63, 8'hc8, 8'h64);
    sample(62, 62, 8'hff, 8'hff);
    sample(62, 63, 8'h01, 8'hfe);
    sample(63, 62, 8'hfe, 8'h01);

    for (int p = 0; p < PHASES; p++) begin
      set_size(phase_w[p], phase_h[p]);
      calm = (p == PHASES - 1);
      // Writes just past the edge must be dropped; a sample past the corner clamps.
      if (cur_w < MAX_WIDTH) write_texel(cur_w, 0, texel_t'($urandom));
      if (cur_h < MAX_HEIGHT) write_texel(0, cur_h, texel_t'($urandom));
      sample(63, 63, pick_frac(), pick_frac());
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          if ($urandom_range(0, 1) == 0)
            sample($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                   pick_frac(), pick_frac());
          else
            sample($urandom_range(0, 63), $urandom_range(0, 63), pick_frac(), pick_frac());
        end else if (r < 80) begin
          write_texel($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                      texel_t'($urandom));
        end else begin
          write_texel($urandom_range(0, 63), $urandom_range(0, 63), texel_t'($urandom));
        end
      end
    end

    idle(1);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d texel transactions over %0d texture sizes, extremes included.",
             sent, settings_used);
    $display("Compared %0d filtered samples; %0d mismatches.", compared, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
